>>> hw/rtl/p2h_pkg.sv
// Shared types and constants for the PS/2 host byte transceiver.
// Holds opcodes, register indexes, reset values and the item structs.
// No dependencies.
`default_nettype none

package p2h_pkg;

   localparam int DATA_BITS    = 8;
   localparam int DELAY_W      = 10;
   localparam int LIMIT_W      = 16;
   localparam int TMO_W        = 17;
   localparam int BIT_IDX_W    = 4;
   localparam int OPCODE_W     = 2;
   localparam int CSR_ADDR_W   = 5;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_IDX_W    = 3;

   localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_RELEASE_WAIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INHIBIT       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REQUEST_HOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_WAIT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WRITE_TIMEOUT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_READ_TIMEOUT  = 3'd5;

   localparam logic [DELAY_W-1:0] RELEASE_WAIT_RST  = 10'd148;
   localparam logic [DELAY_W-1:0] INHIBIT_RST       = 10'd149;
   localparam logic [DELAY_W-1:0] REQUEST_HOLD_RST  = 10'd5;
   localparam logic [DELAY_W-1:0] STOP_WAIT_RST     = 10'd31;
   localparam logic [LIMIT_W-1:0] WRITE_TIMEOUT_RST = 16'd15000;
   localparam logic [LIMIT_W-1:0] READ_TIMEOUT_RST  = 16'd2000;

   localparam logic [TMO_W-1:0] TMO_SAT = {TMO_W{1'b1}};

   typedef struct packed {
      logic [DELAY_W-1:0] release_wait_us;
      logic [DELAY_W-1:0] inhibit_us;
      logic [DELAY_W-1:0] request_hold_us;
      logic [DELAY_W-1:0] stop_wait_us;
      logic [LIMIT_W-1:0] write_timeout_us;
      logic [LIMIT_W-1:0] read_timeout_us;
   } cfg_type;

   typedef struct packed {
      logic [OPCODE_W-1:0]  opcode;
      logic                 clock_level;
      logic                 data_level;
      logic [DATA_BITS-1:0] write_byte;
      logic                 use_timeout;
   } req_item_type;

   typedef struct packed {
      logic                 clock_drive_low;
      logic                 data_drive_low;
      logic                 busy_res;
      logic                 done_res;
      logic                 status;
      logic [DATA_BITS-1:0] read_byte;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> hw/rtl/p2h_if.sv
// Valid/ready channel interfaces for the request and response transactions.
// Depends on p2h_pkg for field widths.
`default_nettype none

interface p2h_req_if;
   import p2h_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OPCODE_W-1:0]  opcode;
   logic                 clock_level;
   logic                 data_level;
   logic [DATA_BITS-1:0] write_byte;
   logic                 use_timeout;

   modport source (output valid, opcode, clock_level, data_level, write_byte, use_timeout,
                   input ready);
   modport sink (input valid, opcode, clock_level, data_level, write_byte, use_timeout,
                 output ready);
endinterface

interface p2h_rsp_if;
   import p2h_pkg::*;
   logic                 valid;
   logic                 ready;
   logic                 clock_drive_low;
   logic                 data_drive_low;
   logic                 busy_res;
   logic                 done_res;
   logic                 status;
   logic [DATA_BITS-1:0] read_byte;

   modport source (output valid, clock_drive_low, data_drive_low, busy_res, done_res,
                   status, read_byte, input ready);
   modport sink (input valid, clock_drive_low, data_drive_low, busy_res, done_res,
                 status, read_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/p2h_csr.sv
// APB-style configuration registers for the PS/2 host transceiver.
// Depends on p2h_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module p2h_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [p2h_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [p2h_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [p2h_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output p2h_pkg::cfg_type                    cfg
);
   import p2h_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [CSR_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_RELEASE_WAIT:  cfg_in.release_wait_us  = pwdata[DELAY_W-1:0];
            REG_INHIBIT:       cfg_in.inhibit_us       = pwdata[DELAY_W-1:0];
            REG_REQUEST_HOLD:  cfg_in.request_hold_us  = pwdata[DELAY_W-1:0];
            REG_STOP_WAIT:     cfg_in.stop_wait_us     = pwdata[DELAY_W-1:0];
            REG_WRITE_TIMEOUT: cfg_in.write_timeout_us = pwdata[LIMIT_W-1:0];
            REG_READ_TIMEOUT:  cfg_in.read_timeout_us  = pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_RELEASE_WAIT:
            prdata = {{(CSR_DATA_W-DELAY_W){1'b0}}, cfg_ff.release_wait_us};
         REG_INHIBIT:
            prdata = {{(CSR_DATA_W-DELAY_W){1'b0}}, cfg_ff.inhibit_us};
         REG_REQUEST_HOLD:
            prdata = {{(CSR_DATA_W-DELAY_W){1'b0}}, cfg_ff.request_hold_us};
         REG_STOP_WAIT:
            prdata = {{(CSR_DATA_W-DELAY_W){1'b0}}, cfg_ff.stop_wait_us};
         REG_WRITE_TIMEOUT:
            prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.write_timeout_us};
         REG_READ_TIMEOUT:
            prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.read_timeout_us};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.release_wait_us  <= RELEASE_WAIT_RST;
         cfg_ff.inhibit_us       <= INHIBIT_RST;
         cfg_ff.request_hold_us  <= REQUEST_HOLD_RST;
         cfg_ff.stop_wait_us     <= STOP_WAIT_RST;
         cfg_ff.write_timeout_us <= WRITE_TIMEOUT_RST;
         cfg_ff.read_timeout_us  <= READ_TIMEOUT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/p2h_core.sv
// Transfer sequencer of the PS/2 host: one step per microsecond tick.
// Depends on p2h_pkg for item structs, cfg_type and constants.
`default_nettype none

module p2h_core (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire p2h_pkg::req_item_type item,
   input  wire p2h_pkg::cfg_type      cfg,
   output p2h_pkg::rsp_item_type      result
);
   import p2h_pkg::*;

   typedef enum logic [4:0] {
      PH_IDLE, PH_W_RELEASE, PH_W_INHIBIT, PH_W_REQ, PH_W_FIRST, PH_W_HIGH,
      PH_W_LOW, PH_W_PHIGH, PH_W_PLOW, PH_W_STOP, PH_W_ACK, PH_W_BOTH,
      PH_R_FIRST, PH_R_START_HIGH, PH_R_LOW, PH_R_HIGH, PH_R_PLOW, PH_R_PHIGH,
      PH_R_SLOW, PH_R_SHIGH
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [DELAY_W-1:0]     delay_ff, delay_in;
   logic [TMO_W-1:0]       tmo_ff, tmo_in;
   logic [BIT_IDX_W-1:0]   bit_ff, bit_in;
   logic [DATA_BITS-1:0]   shift_ff, shift_in;
   logic                   parity_ff, parity_in;
   logic                   tmo_en_ff, tmo_en_in;
   logic                   clk_pull_ff, clk_pull_in;
   logic                   dat_pull_ff, dat_pull_in;

   logic [DELAY_W-1:0]     delay_limit;
   logic                   delay_done;
   logic [LIMIT_W-1:0]     tmo_limit;
   logic                   tmo_fail;
   logic [BIT_IDX_W-1:0]   bit_next;
   logic [2:0]             tx_idx;
   logic                   tx_bit;
   logic                   done;
   logic                   fail;

   assign bit_next = bit_ff + 1'b1;

   always_comb begin
      case (phase_ff)
         PH_W_RELEASE: delay_limit = cfg.release_wait_us;
         PH_W_INHIBIT: delay_limit = cfg.inhibit_us;
         PH_W_REQ:     delay_limit = cfg.request_hold_us;
         default:      delay_limit = cfg.stop_wait_us;
      endcase
   end

   assign delay_done = (delay_ff >= delay_limit);
   assign tmo_limit  = (phase_ff == PH_R_FIRST) ? cfg.read_timeout_us : cfg.write_timeout_us;
   assign tmo_fail   = tmo_en_ff && (tmo_ff > {1'b0, tmo_limit});
   assign tx_idx     = (phase_ff == PH_W_FIRST) ? bit_ff[2:0] : bit_next[2:0];
   assign tx_bit     = shift_ff[tx_idx];

   always_comb begin
      phase_in    = phase_ff;
      delay_in    = delay_ff;
      tmo_in      = tmo_ff;
      bit_in      = bit_ff;
      shift_in    = shift_ff;
      parity_in   = parity_ff;
      tmo_en_in   = tmo_en_ff;
      clk_pull_in = clk_pull_ff;
      dat_pull_in = dat_pull_ff;
      done        = 1'b0;
      fail        = 1'b0;

      case (phase_ff)
         PH_IDLE: begin
            if (item.opcode == OP_WRITE || item.opcode == OP_READ) begin
               clk_pull_in = 1'b0;
               dat_pull_in = 1'b0;
               delay_in    = '0;
               tmo_in      = '0;
               bit_in      = '0;
               parity_in   = 1'b1;
               tmo_en_in   = item.use_timeout;
               if (item.opcode == OP_WRITE) begin
                  shift_in = item.write_byte;
                  phase_in = PH_W_RELEASE;
               end else begin
                  shift_in = '0;
                  phase_in = PH_R_FIRST;
               end
            end
         end
         PH_W_RELEASE, PH_W_INHIBIT, PH_W_REQ, PH_W_STOP: begin
            if (delay_done) begin
               delay_in = '0;
               case (phase_ff)
                  PH_W_RELEASE: begin
                     clk_pull_in = 1'b1;
                     phase_in    = PH_W_INHIBIT;
                  end
                  PH_W_INHIBIT: begin
                     dat_pull_in = 1'b1;
                     phase_in    = PH_W_REQ;
                  end
                  PH_W_REQ: begin
                     clk_pull_in = 1'b0;
                     tmo_in      = '0;
                     phase_in    = PH_W_FIRST;
                  end
                  default: begin
                     dat_pull_in = 1'b0;
                     phase_in    = PH_W_ACK;
                  end
               endcase
            end else begin
               delay_in = delay_ff + 1'b1;
            end
         end
         PH_W_FIRST, PH_R_FIRST: begin
            if (!item.clock_level) begin
               if (phase_ff == PH_W_FIRST) begin
                  dat_pull_in = !tx_bit;
                  parity_in   = parity_ff ^ tx_bit;
                  phase_in    = PH_W_HIGH;
               end else begin
                  phase_in = PH_R_START_HIGH;
               end
            end else if (tmo_fail) begin
               done     = 1'b1;
               fail     = 1'b1;
               phase_in = PH_IDLE;
               if (phase_ff == PH_R_FIRST) begin
                  clk_pull_in = 1'b1;
               end
            end else if (tmo_en_ff && tmo_ff != TMO_SAT) begin
               tmo_in = tmo_ff + 1'b1;
            end
         end
         PH_W_HIGH: begin
            if (item.clock_level) begin
               phase_in = PH_W_LOW;
            end
         end
         PH_W_LOW: begin
            if (!item.clock_level) begin
               bit_in = bit_next;
               if (bit_next < BIT_IDX_W'(DATA_BITS)) begin
                  dat_pull_in = !tx_bit;
                  parity_in   = parity_ff ^ tx_bit;
                  phase_in    = PH_W_HIGH;
               end else begin
                  dat_pull_in = !parity_ff;
                  phase_in    = PH_W_PHIGH;
               end
            end
         end
         PH_W_PHIGH: begin
            if (item.clock_level) begin
               phase_in = PH_W_PLOW;
            end
         end
         PH_W_PLOW: begin
            if (!item.clock_level) begin
               delay_in = '0;
               phase_in = PH_W_STOP;
            end
         end
         PH_W_ACK: begin
            if (!item.clock_level) begin
               phase_in = PH_W_BOTH;
            end
         end
         PH_W_BOTH: begin
            if (item.clock_level && item.data_level) begin
               clk_pull_in = 1'b1;
               done        = 1'b1;
               phase_in    = PH_IDLE;
            end
         end
         PH_R_START_HIGH: begin
            if (item.clock_level) begin
               bit_in   = '0;
               phase_in = PH_R_LOW;
            end
         end
         PH_R_LOW: begin
            if (!item.clock_level) begin
               if (item.data_level) begin
                  shift_in[bit_ff[2:0]] = 1'b1;
               end
               phase_in = PH_R_HIGH;
            end
         end
         PH_R_HIGH: begin
            if (item.clock_level) begin
               bit_in   = bit_next;
               phase_in = (bit_next < BIT_IDX_W'(DATA_BITS)) ? PH_R_LOW : PH_R_PLOW;
            end
         end
         PH_R_PLOW: begin
            if (!item.clock_level) begin
               phase_in = PH_R_PHIGH;
            end
         end
         PH_R_PHIGH: begin
            if (item.clock_level) begin
               phase_in = PH_R_SLOW;
            end
         end
         PH_R_SLOW: begin
            if (!item.clock_level) begin
               phase_in = PH_R_SHIGH;
            end
         end
         PH_R_SHIGH: begin
            if (item.clock_level) begin
               clk_pull_in = 1'b1;
               done        = 1'b1;
               phase_in    = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   assign result.clock_drive_low = clk_pull_in;
   assign result.data_drive_low  = dat_pull_in;
   assign result.busy_res        = (phase_in != PH_IDLE);
   assign result.done_res        = done;
   assign result.status          = fail;
   assign result.read_byte       = shift_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         delay_ff    <= '0;
         tmo_ff      <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         parity_ff   <= 1'b1;
         tmo_en_ff   <= 1'b0;
         clk_pull_ff <= 1'b0;
         dat_pull_ff <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         delay_ff    <= delay_in;
         tmo_ff      <= tmo_in;
         bit_ff      <= bit_in;
         shift_ff    <= shift_in;
         parity_ff   <= parity_in;
         tmo_en_ff   <= tmo_en_in;
         clk_pull_ff <= clk_pull_in;
         dat_pull_ff <= dat_pull_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/ps2_host_byte_transceiver.sv
// PS/2 host byte transceiver, top level.
// Depends on p2h_pkg, p2h_if, p2h_csr and p2h_core.
//
// Usage: every request transaction is one microsecond tick carrying the
// sampled clock and data line levels and an opcode (tick, start write, start
// read). Every request yields exactly one response transaction with the line
// pulls to apply, busy, done, status (timed out) and the last byte shifted.
// Starts are taken only while idle; otherwise the tick runs the transfer on.
// A request passes the input register, then the result register, before its
// response is valid. Throughput: one transaction per cycle unless the response
// side stalls; the sequencer's single-step next-state logic sets that figure.
// Reset releases both lines, idles the sequencer, clears the read byte and
// loads the default timings. The APB registers hold the timings and the
// first-clock timeout limits; write them only while idle.
// When the response side stalls, the result register holds its transaction,
// the input register keeps or takes one more request, then req.ready drops.
`default_nettype none

module ps2_host_byte_transceiver (
   input  wire logic                           clock,
   input  wire logic                           reset,
   p2h_req_if.sink                             req,
   p2h_rsp_if.source                           rsp,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [p2h_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [p2h_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [p2h_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import p2h_pkg::*;

   cfg_type       cfg;
   req_item_type  in_item_ff, in_item_in;
   logic          in_valid_ff, in_valid_in;
   rsp_item_type  out_item_ff, out_item_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  result;
   logic          out_free;
   logic          advance;
   logic          req_take;

   p2h_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   p2h_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign out_free  = !out_valid_ff || rsp.ready;
   assign advance   = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in             = 1'b1;
         in_item_in.opcode       = req.opcode;
         in_item_in.clock_level  = req.clock_level;
         in_item_in.data_level   = req.data_level;
         in_item_in.write_byte   = req.write_byte;
         in_item_in.use_timeout  = req.use_timeout;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = result;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.clock_drive_low = out_item_ff.clock_drive_low;
   assign rsp.data_drive_low  = out_item_ff.data_drive_low;
   assign rsp.busy_res        = out_item_ff.busy_res;
   assign rsp.done_res        = out_item_ff.done_res;
   assign rsp.status          = out_item_ff.status;
   assign rsp.read_byte       = out_item_ff.read_byte;

endmodule

`default_nettype wire
